// ===== rtl/core/assert_macros.svh =====
// assertion macros for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FEGR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fegr assertion failed");
`define FEGR_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fegr assertion failed");
`else
`define FEGR_ASSERT(lbl, prop)
`define FEGR_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/fegr_pkg.sv =====
// shared types, constants and exp table for the fiber end growth rate core
`timescale 1ns / 1ps
package fegr_pkg;

	localparam int EXP_DEPTH = 256;
	localparam bit KEEP_SHORT = 1'b0;

	localparam int ROM_AW = $clog2(EXP_DEPTH + 1);
	localparam int POS_W = 20 + ROM_AW;
	localparam int NUM_W = 62;
	localparam int DEN_W = 33;
	localparam int QUO_W = 32;
	localparam int LATENCY = NUM_W + 8;

	localparam logic [1:0] MODE_GROW = 2'd1;
	localparam logic [1:0] MODE_SHRINK = 2'd2;

	typedef enum logic [2:0] {
		CFG_GROW_PLUS = 3'd0,
		CFG_GROW_MINUS = 3'd1,
		CFG_SHRINK_PLUS = 3'd2,
		CFG_SHRINK_MINUS = 3'd3,
		CFG_GAIN_PLUS = 3'd4,
		CFG_GAIN_MINUS = 3'd5,
		CFG_FLOOR = 3'd6,
		CFG_CEILING = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		DEC_REMOVE,
		DEC_SHORT,
		DEC_APPLY,
		DEC_SCALE,
		DEC_DROP
	} dec_t;

	typedef struct packed {
		logic [30:0] grow;
		logic signed [31:0] shrink;
		logic [30:0] gain;
	} end_cfg_t;

	typedef struct packed {
		end_cfg_t plus;
		end_cfg_t minus;
		logic [30:0] floor_len;
		logic [30:0] ceil_len;
	} cfg_t;

	typedef struct packed {
		dec_t dec;
		logic signed [31:0] gp;
		logic signed [31:0] gm;
	} tag_t;

	typedef logic [16:0] exp_rom_t [EXP_DEPTH + 1];

	// floor(a*b / 2^56)
	function automatic longint unsigned mul_q56(longint unsigned a, longint unsigned b);
		longint unsigned ah, al, bh, bl, mid;
		ah = a >> 32;
		al = a & 64'hFFFF_FFFF;
		bh = b >> 32;
		bl = b & 64'hFFFF_FFFF;
		mid = ah * bl + al * bh + ((al * bl) >> 32);
		return ((ah * bh) << 8) + (mid >> 24);
	endfunction

	// floor(n / d) by shift and subtract, only used while building the table
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q, r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		longint unsigned term, pos, neg, r, v;
		term = 64'd1 << 56;
		pos = 64'd1 << 56;
		neg = 64'd0;
		for (int k = 1; k <= 40; k++) begin
			if (term != 64'd0) begin
				term = udiv64(term * 64'd16, 64'(EXP_DEPTH) * 64'(k));
				if (k[0] == 1'b1) neg = neg + term;
				else pos = pos + term;
			end
		end
		r = pos - neg;
		v = 64'd1 << 56;
		rom[0] = 17'd65536;
		for (int i = 1; i <= EXP_DEPTH; i++) begin
			v = mul_q56(v, r);
			rom[i] = 17'((v + (64'd1 << 39)) >> 40);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== rtl/core/fegr_cfg.sv =====
// configuration register file
`timescale 1ns / 1ps
module fegr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output fegr_pkg::cfg_t    cfg
);
	import fegr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{plus: '0, minus: '0, floor_len: '0, ceil_len: 31'h7FFF_FFFF};
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GROW_PLUS: cfg_q.plus.grow <= cfg_data[30:0];
				CFG_GROW_MINUS: cfg_q.minus.grow <= cfg_data[30:0];
				CFG_SHRINK_PLUS: cfg_q.plus.shrink <= cfg_data;
				CFG_SHRINK_MINUS: cfg_q.minus.shrink <= cfg_data;
				CFG_GAIN_PLUS: cfg_q.plus.gain <= cfg_data[30:0];
				CFG_GAIN_MINUS: cfg_q.minus.gain <= cfg_data[30:0];
				CFG_FLOOR: cfg_q.floor_len <= cfg_data[30:0];
				CFG_CEILING: cfg_q.ceil_len <= cfg_data[30:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end
endmodule

// ===== rtl/core/fegr_end_rate.sv =====
// five stage rate pipeline for one fiber end, with force damping
`timescale 1ns / 1ps
module fegr_end_rate (
	input  logic                  clk,
	input  logic [1:0]            mode,
	input  logic signed [31:0]    force_in,
	input  logic [16:0]           frac,
	input  fegr_pkg::end_cfg_t    ecfg,
	output logic signed [31:0]    rate_s5
);
	import fegr_pkg::*;

	logic [47:0] gprod;
	logic [31:0] mag;
	logic [62:0] dprod;

	logic [1:0]  mode_s1, mode_s2, mode_s3, mode_s4;
	logic        neg_s1;
	logic [30:0] g_s1, g_s2, g_s3, g_s4;
	logic [62:0] dprod_s1;

	logic        damp_s2, damp_s3, damp_s4;
	logic        big_s2, big_s3;
	logic [16:0] hi_s2, hi_s3;
	logic [16:0] diff_s2;
	logic [15:0] t_s2;
	logic [32:0] iprod_s3;
	logic [47:0] rprod_s4;

	logic [19:0]       u;
	logic [POS_W-1:0]  pos;
	logic [ROM_AW-1:0] idx, idx_nxt;
	logic [16:0]       hi, lo;
	logic [16:0]       factor;

	assign gprod = {17'd0, ecfg.grow} * {31'd0, frac};
	assign mag = 32'(-force_in);
	assign dprod = {31'd0, mag} * {32'd0, ecfg.gain};

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		neg_s1 <= force_in[31];
		g_s1 <= gprod[46:16];
		dprod_s1 <= dprod;
	end

	// table position from the damping argument
	assign u = dprod_s1[35:16];
	assign pos = POS_W'(u) * POS_W'(EXP_DEPTH);
	assign idx = pos[POS_W-1:20];
	assign idx_nxt = idx + ROM_AW'(1);
	assign hi = EXP_ROM[idx];
	assign lo = (EXP_ROM[idx_nxt] > hi) ? hi : EXP_ROM[idx_nxt];

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		g_s2 <= g_s1;
		damp_s2 <= neg_s1 && (g_s1 != 31'd0);
		big_s2 <= |dprod_s1[62:36];
		hi_s2 <= hi;
		diff_s2 <= hi - lo;
		t_s2 <= pos[19:4];
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		g_s3 <= g_s2;
		damp_s3 <= damp_s2;
		big_s3 <= big_s2;
		hi_s3 <= hi_s2;
		iprod_s3 <= {16'd0, diff_s2} * {17'd0, t_s2};
	end

	// beyond the table the factor is zero
	assign factor = big_s3 ? 17'd0 : (hi_s3 - iprod_s3[32:16]);

	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		g_s4 <= g_s3;
		damp_s4 <= damp_s3;
		rprod_s4 <= {17'd0, g_s3} * {31'd0, factor};
	end

	always_ff @(posedge clk) begin
		if (mode_s4 == MODE_GROW)
			rate_s5 <= {1'b0, (damp_s4 ? rprod_s4[46:16] : g_s4)};
		else if (mode_s4 == MODE_SHRINK)
			rate_s5 <= ecfg.shrink;
		else
			rate_s5 <= '0;
	end
endmodule

// ===== rtl/core/fegr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, low quotient bits kept
`timescale 1ns / 1ps
module fegr_div (
	input  logic                         clk,
	input  logic [fegr_pkg::NUM_W-1:0]   num,
	input  logic [fegr_pkg::DEN_W-1:0]   den,
	output logic [fegr_pkg::QUO_W-1:0]   quo
);
	import fegr_pkg::*;

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [QUO_W-1:0] quo_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar j = 0; j < NUM_W; j++) begin : g_stage
		logic [DEN_W-1:0] rem_in, den_in;
		logic [NUM_W-1:0] num_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W:0]   shifted, trial;
		logic             ok;

		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign num_in = num_s[j-1];
			assign quo_in = quo_s[j-1];
			assign den_in = den_s[j-1];
		end

		assign shifted = {rem_in, num_in[NUM_W-1]};
		assign trial = shifted - {1'b0, den_in};
		// remainder stays below the divisor, so the top bit is the borrow
		assign ok = !trial[DEN_W];

		always_ff @(posedge clk) begin
			rem_s[j] <= ok ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			num_s[j] <= {num_in[NUM_W-2:0], 1'b0};
			quo_s[j] <= {quo_in[QUO_W-2:0], ok};
			den_s[j] <= den_in;
		end
	end

	assign quo = quo_s[NUM_W-1];
endmodule

// ===== rtl/core/fiber_end_growth_rate_core.sv =====
// Fiber end growth rate core: takes one fiber per clock and returns its end length
// changes and apply/remove flags, each marked by done (done strobes for one
// cycle). Most of the pipeline is the 62-stage pipelined divider that scales both rates
// to land on the length ceiling; ahead of it sit seven stages of multiply, exp table
// lookup with interpolation and limit checks. busy is always low and the result port
// cannot be held off, so nothing in the pipeline ever stalls.
`timescale 1ns / 1ps
module fiber_end_growth_rate_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         plus_mode,
	input  logic [1:0]         minus_mode,
	input  logic signed [31:0] plus_force,
	input  logic signed [31:0] minus_force,
	input  logic [30:0]        fiber_length,
	input  logic [16:0]        monomer_fraction,
	output logic               done,
	output logic signed [31:0] plus_growth,
	output logic signed [31:0] minus_growth,
	output logic               apply_growth,
	output logic               remove_fiber,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import fegr_pkg::*;
	`include "assert_macros.svh"

	cfg_t cfg;
	logic [16:0] frac;
	logic signed [31:0] gp_s5, gm_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [30:0] len_s1, len_s2, len_s3, len_s4, len_s5;

	logic signed [32:0] inc;
	logic signed [33:0] sum, len_x;
	dec_t dec;

	tag_t tag_s6, tag_s7;
	logic [30:0] rem_s6;
	logic [32:0] inc_s6;
	logic [NUM_W-1:0] nump_s7, numm_s7;
	logic [DEN_W-1:0] den_s7;
	logic [31:0] magp, magm;
	logic [62:0] prodp, prodm;

	tag_t tag_s [NUM_W];
	logic vd_s [NUM_W];
	logic [QUO_W-1:0] qp, qm;
	tag_t tag_out;

	logic signed [31:0] plus_nxt, minus_nxt;
	logic apply_nxt, remove_nxt;

	assign busy = 1'b0;

	fegr_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	assign frac = (monomer_fraction > 17'd65536) ? 17'd65536 : monomer_fraction;

	fegr_end_rate u_plus (
		.clk(clk), .mode(plus_mode), .force_in(plus_force), .frac(frac),
		.ecfg(cfg.plus), .rate_s5(gp_s5)
	);

	fegr_end_rate u_minus (
		.clk(clk), .mode(minus_mode), .force_in(minus_force), .frac(frac),
		.ecfg(cfg.minus), .rate_s5(gm_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		len_s1 <= fiber_length;
		len_s2 <= len_s1;
		len_s3 <= len_s2;
		len_s4 <= len_s3;
		len_s5 <= len_s4;
	end

	// length limit checks, floor first
	assign inc = 33'(gp_s5) + 33'(gm_s5);
	assign len_x = $signed({3'b000, len_s5});
	assign sum = len_x + 34'(inc);

	always_comb begin
		if (sum < $signed({3'b000, cfg.floor_len}))
			dec = KEEP_SHORT ? DEC_SHORT : DEC_REMOVE;
		else if (sum < $signed({3'b000, cfg.ceil_len}))
			dec = DEC_APPLY;
		else if ((len_s5 < cfg.ceil_len) && (inc > 33'sd0))
			dec = DEC_SCALE;
		else
			dec = DEC_DROP;
	end

	always_ff @(posedge clk) begin
		tag_s6.dec <= dec;
		tag_s6.gp <= gp_s5;
		tag_s6.gm <= gm_s5;
		rem_s6 <= cfg.ceil_len - len_s5;
		inc_s6 <= inc;
	end

	assign magp = 32'(tag_s6.gp[31] ? -tag_s6.gp : tag_s6.gp);
	assign magm = 32'(tag_s6.gm[31] ? -tag_s6.gm : tag_s6.gm);
	assign prodp = {31'd0, magp} * {32'd0, rem_s6};
	assign prodm = {31'd0, magm} * {32'd0, rem_s6};

	always_ff @(posedge clk) begin
		tag_s7 <= tag_s6;
		nump_s7 <= prodp[NUM_W-1:0];
		numm_s7 <= prodm[NUM_W-1:0];
		den_s7 <= inc_s6;
	end

	fegr_div u_div_plus (.clk(clk), .num(nump_s7), .den(den_s7), .quo(qp));
	fegr_div u_div_minus (.clk(clk), .num(numm_s7), .den(den_s7), .quo(qm));

	// item tag rides alongside the divider stages
	always_ff @(posedge clk) begin
		tag_s[0] <= tag_s7;
		for (int i = 1; i < NUM_W; i++) tag_s[i] <= tag_s[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_W; i++) vd_s[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			vd_s[0] <= v_s7;
			for (int i = 1; i < NUM_W; i++) vd_s[i] <= vd_s[i-1];
			done <= vd_s[NUM_W-1];
		end
	end

	assign tag_out = tag_s[NUM_W-1];

	always_comb begin
		plus_nxt = '0;
		minus_nxt = '0;
		apply_nxt = 1'b0;
		remove_nxt = 1'b0;
		case (tag_out.dec)
			DEC_REMOVE: remove_nxt = 1'b1;
			DEC_SHORT: begin
				plus_nxt = tag_out.gp;
				minus_nxt = tag_out.gm;
			end
			DEC_APPLY: begin
				plus_nxt = tag_out.gp;
				minus_nxt = tag_out.gm;
				apply_nxt = 1'b1;
			end
			DEC_SCALE: begin
				plus_nxt = tag_out.gp[31] ? -$signed(qp) : $signed(qp);
				minus_nxt = tag_out.gm[31] ? -$signed(qm) : $signed(qm);
				apply_nxt = 1'b1;
			end
			default: apply_nxt = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		plus_growth <= plus_nxt;
		minus_growth <= minus_nxt;
		apply_growth <= apply_nxt;
		remove_fiber <= remove_nxt;
	end

	`FEGR_IMPLY(a_flags_exclusive, done, !(apply_growth && remove_fiber))
	`FEGR_IMPLY(a_removed_zero, done && remove_fiber, plus_growth == 0 && minus_growth == 0)
	`FEGR_ASSERT(a_latency, start |-> ##LATENCY done)
endmodule

// ===== test/tb_fiber_end_growth_rate_core.sv =====
// self-checking testbench for the fiber end growth rate core
`timescale 1ns / 1ps
module tb_fiber_end_growth_rate_core;
	import fegr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = LATENCY + 10;
	localparam int TABLE_DEPTH = 256;

	typedef struct {
		logic signed [31:0] plus_growth;
		logic signed [31:0] minus_growth;
		logic apply_growth;
		logic remove_fiber;
	} growth_t;

	class growth_scoreboard;
		longint unsigned grow_p, grow_m, gain_p, gain_m, floor_len, ceil_len;
		longint shrink_p, shrink_m;
		longint unsigned exp_table [TABLE_DEPTH + 1];
		growth_t pending_q [$];
		int errors;

		function new();
			longint unsigned term, pos, neg, ratio, v;
			logic [127:0] prod;
			grow_p = 0; grow_m = 0; gain_p = 0; gain_m = 0;
			shrink_p = 0; shrink_m = 0; floor_len = 0; ceil_len = 64'h7FFF_FFFF;
			errors = 0;
			term = 64'd1 << 56;
			pos = 64'd1 << 56;
			neg = 0;
			for (int k = 1; k <= 40; k++) begin
				if (term != 0) begin
					term = term * 16 / (TABLE_DEPTH * k);
					if (k % 2) neg += term;
					else pos += term;
				end
			end
			ratio = pos - neg;
			v = 64'd1 << 56;
			exp_table[0] = 65536;
			for (int i = 1; i <= TABLE_DEPTH; i++) begin
				prod = 128'(v) * 128'(ratio);
				v = 64'(prod >> 56);
				exp_table[i] = (v + (64'd1 << 39)) >> 40;
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (cfg_idx_t'(idx))
				CFG_GROW_PLUS: grow_p = data[30:0];
				CFG_GROW_MINUS: grow_m = data[30:0];
				CFG_SHRINK_PLUS: shrink_p = longint'(signed'(data));
				CFG_SHRINK_MINUS: shrink_m = longint'(signed'(data));
				CFG_GAIN_PLUS: gain_p = data[30:0];
				CFG_GAIN_MINUS: gain_m = data[30:0];
				CFG_FLOOR: floor_len = data[30:0];
				CFG_CEILING: ceil_len = data[30:0];
				default: ;
			endcase
		endfunction

		// exp(-u) from the table with linear interpolation, zero from -16 down
		function longint unsigned exp_damp(longint unsigned u);
			longint unsigned p, idx, t, hi, lo;
			if (u >= (64'd16 << 16)) return 0;
			p = u * TABLE_DEPTH;
			idx = p >> 20;
			t = (p >> 4) & 64'hFFFF;
			if (idx >= TABLE_DEPTH) return 0;
			hi = exp_table[idx];
			lo = exp_table[idx + 1];
			if (lo > hi) lo = hi;
			return hi - (((hi - lo) * t) >> 16);
		endfunction

		function longint end_rate(logic [1:0] mode, logic [31:0] frc, longint unsigned speed,
				longint shrink, longint unsigned gain, longint unsigned frac);
			longint unsigned g, mag;
			if (mode == MODE_GROW) begin
				g = (speed * frac) >> 16;
				if (frc[31] && g > 0) begin
					mag = longint'(32'(-frc));
					if (mag == 0) mag = 64'd1 << 31;
					g = (g * exp_damp((mag * gain) >> 16)) >> 16;
				end
				return longint'(g);
			end
			if (mode == MODE_SHRINK) return shrink;
			return 0;
		endfunction

		function void note_item(logic [1:0] pm, logic [1:0] mm, logic [31:0] pf,
				logic [31:0] mf, logic [30:0] len_in, logic [16:0] frac_in);
			longint unsigned frac;
			longint gp, gm, len, inc, total, rem;
			growth_t res;
			frac = (frac_in > 17'd65536) ? 65536 : frac_in;
			gp = end_rate(pm, pf, grow_p, shrink_p, gain_p, frac);
			gm = end_rate(mm, mf, grow_m, shrink_m, gain_m, frac);
			len = len_in;
			inc = gp + gm;
			total = len + inc;
			res.apply_growth = 0;
			res.remove_fiber = 0;
			if (total < longint'(floor_len)) begin
				if (!KEEP_SHORT) begin
					res.remove_fiber = 1;
					gp = 0;
					gm = 0;
				end
			end else if (total < longint'(ceil_len)) begin
				res.apply_growth = 1;
			end else if (len < longint'(ceil_len) && inc > 0) begin
				rem = longint'(ceil_len) - len;
				gp = (gp * rem) / inc;
				gm = (gm * rem) / inc;
				res.apply_growth = 1;
			end else begin
				gp = 0;
				gm = 0;
			end
			res.plus_growth = gp[31:0];
			res.minus_growth = gm[31:0];
			pending_q.push_back(res);
		endfunction

		function void check_result(growth_t got);
			growth_t exp_r;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result plus %0d minus %0d", $time,
					got.plus_growth, got.minus_growth);
				errors++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.plus_growth !== exp_r.plus_growth) begin
				$display("%0t: plus_growth expected %0d actual %0d", $time,
					exp_r.plus_growth, got.plus_growth);
				errors++;
			end
			if (got.minus_growth !== exp_r.minus_growth) begin
				$display("%0t: minus_growth expected %0d actual %0d", $time,
					exp_r.minus_growth, got.minus_growth);
				errors++;
			end
			if (got.apply_growth !== exp_r.apply_growth) begin
				$display("%0t: apply_growth expected %0b actual %0b", $time,
					exp_r.apply_growth, got.apply_growth);
				errors++;
			end
			if (got.remove_fiber !== exp_r.remove_fiber) begin
				$display("%0t: remove_fiber expected %0b actual %0b", $time,
					exp_r.remove_fiber, got.remove_fiber);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, apply_growth, remove_fiber;
	logic [1:0] plus_mode, minus_mode;
	logic signed [31:0] plus_force, minus_force, plus_growth, minus_growth;
	logic [30:0] fiber_length;
	logic [16:0] monomer_fraction;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	growth_scoreboard sb;
	int cycles;
	bit allow_gaps;
	longint unsigned cur_floor, cur_ceil;

	fiber_end_growth_rate_core dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// sample accepted items, register writes and results
	always @(posedge clk) begin
		growth_t got;
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(plus_mode, minus_mode, plus_force, minus_force, fiber_length,
					monomer_fraction);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (done) begin
				got.plus_growth = plus_growth;
				got.minus_growth = minus_growth;
				got.apply_growth = apply_growth;
				got.remove_fiber = remove_fiber;
				sb.check_result(got);
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_FLOOR) cur_floor = data[30:0];
		if (idx == CFG_CEILING) cur_ceil = data[30:0];
	endtask

	task automatic send_fiber(logic [1:0] pm, logic [1:0] mm, logic [31:0] pf,
			logic [31:0] mf, logic [30:0] len, logic [16:0] frac);
		if (allow_gaps && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		plus_mode = pm;
		minus_mode = mm;
		plus_force = pf;
		minus_force = mf;
		fiber_length = len;
		monomer_fraction = frac;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(int kind);
		logic [31:0] fl;
		case (kind)
			0: begin
				write_reg(CFG_GROW_PLUS, 32'h0001_0000);
				write_reg(CFG_GROW_MINUS, 32'h0002_0000);
				write_reg(CFG_SHRINK_PLUS, -32'sh0000_8000);
				write_reg(CFG_SHRINK_MINUS, -32'sh0001_0000);
				write_reg(CFG_GAIN_PLUS, 32'h0001_0000);
				write_reg(CFG_GAIN_MINUS, 32'h0000_4000);
				write_reg(CFG_FLOOR, 32'h0001_0000);
				write_reg(CFG_CEILING, 32'h0064_0000);
			end
			1: begin
				write_reg(CFG_GROW_PLUS, 32'h7FFF_FFFF);
				write_reg(CFG_GROW_MINUS, 32'hFFFF_FFFF);
				write_reg(CFG_SHRINK_PLUS, 32'h8000_0000);
				write_reg(CFG_SHRINK_MINUS, 32'h8000_0000);
				write_reg(CFG_GAIN_PLUS, 32'h7FFF_FFFF);
				write_reg(CFG_GAIN_MINUS, 32'hFFFF_FFFF);
				write_reg(CFG_FLOOR, 32'h0000_0000);
				write_reg(CFG_CEILING, 32'h7FFF_FFFF);
			end
			2: begin
				// zero speeds, positive shrink, floor above ceiling
				write_reg(CFG_GROW_PLUS, 32'h0);
				write_reg(CFG_GROW_MINUS, 32'h0);
				write_reg(CFG_SHRINK_PLUS, 32'h0003_0000);
				write_reg(CFG_SHRINK_MINUS, 32'h0);
				write_reg(CFG_GAIN_PLUS, 32'h0);
				write_reg(CFG_GAIN_MINUS, 32'h0);
				write_reg(CFG_FLOOR, 32'h0010_0000);
				write_reg(CFG_CEILING, 32'h0008_0000);
			end
			default: begin
				write_reg(CFG_GROW_PLUS, $urandom_range(0, 1 << 20));
				write_reg(CFG_GROW_MINUS, $urandom_range(0, 1 << 20));
				write_reg(CFG_SHRINK_PLUS, -$urandom_range(0, 1 << 20));
				write_reg(CFG_SHRINK_MINUS, -$urandom_range(0, 1 << 20));
				write_reg(CFG_GAIN_PLUS, $urandom_range(0, 1 << 18));
				write_reg(CFG_GAIN_MINUS, $urandom_range(0, 1 << 18));
				fl = $urandom_range(0, 1 << 22);
				write_reg(CFG_FLOOR, fl);
				write_reg(CFG_CEILING, fl + $urandom_range(0, 1 << 24));
			end
		endcase
	endtask

	function automatic logic [31:0] pick_force();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return -$urandom_range(0, 1 << 21);
			2: return $urandom_range(0, 1 << 21);
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
			default: return -$urandom_range(0, 1 << 17);
		endcase
	endfunction

	// half of the lengths cluster around the floor and ceiling so the limit decisions get hit
	function automatic logic [30:0] pick_length();
		longint v;
		case ($urandom_range(0, 3))
			0: v = longint'(cur_ceil) + $urandom_range(0, 1 << 22) - (1 << 21);
			1: v = longint'(cur_floor) + $urandom_range(0, 1 << 22) - (1 << 21);
			2: v = $urandom;
			default: v = $urandom_range(0, 1 << 24);
		endcase
		if (v < 0) v = 0;
		if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
		return v[30:0];
	endfunction

	function automatic logic [16:0] pick_fraction();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 17'd65536;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	initial begin
		sb = new();
		cycles = 0;
		allow_gaps = 1'b0;
		cur_floor = 0;
		cur_ceil = 64'h7FFF_FFFF;
		arst_n = 1'b0;
		start = 1'b0;
		plus_mode = '0;
		minus_mode = '0;
		plus_force = '0;
		minus_force = '0;
		fiber_length = '0;
		monomer_fraction = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values first
		send_fiber(MODE_GROW, MODE_SHRINK, 32'h0, 32'h0, 31'h10_0000, 17'd65536);
		wait_idle();
		load_config(0);
		send_fiber(2'd0, 2'd0, 32'h0, 32'h0, 31'h10_0000, 17'd0);
		send_fiber(2'd3, 2'd3, 32'hFFFF_0000, 32'h7FFF_FFFF, 31'h10_0000, 17'd65536);
		send_fiber(MODE_GROW, MODE_GROW, 32'h0, 32'h7FFF_FFFF, 31'h10_0000, 17'd65536);
		send_fiber(MODE_GROW, MODE_GROW, 32'hFFFF_FFFF, 32'hFFFF_0000, 31'h10_0000,
			17'd32768);
		send_fiber(MODE_GROW, MODE_GROW, 32'h8000_0000, 32'hFFF0_0000, 31'h10_0000,
			17'd65536);
		send_fiber(MODE_GROW, MODE_GROW, 32'hFFF0_0001, 32'hFFC0_0000, 31'h10_0000,
			17'h1FFFF);
		send_fiber(MODE_GROW, MODE_GROW, 32'hFFF8_0000, 32'h0, 31'h10_0000, 17'd0);
		send_fiber(MODE_SHRINK, MODE_SHRINK, 32'h0, 32'h0, 31'h10_0000, 17'd65536);
		send_fiber(MODE_SHRINK, MODE_SHRINK, 32'h0, 32'h0, 31'h0, 17'd65536);
		send_fiber(MODE_SHRINK, 2'd0, 32'h0, 32'h0, 31'h0001_8000, 17'd65536);
		send_fiber(MODE_GROW, MODE_GROW, 32'h0, 32'h0, 31'h0063_0000, 17'd65536);
		send_fiber(MODE_GROW, MODE_SHRINK, 32'h0, 32'h0, 31'h0063_8000, 17'd65536);
		send_fiber(MODE_GROW, MODE_GROW, 32'h0, 32'h0, 31'h0064_0000, 17'd65536);
		send_fiber(MODE_GROW, MODE_GROW, 32'h0, 32'h0, 31'h7FFF_FFFF, 17'd65536);
		send_fiber(MODE_SHRINK, MODE_GROW, 32'h0, 32'h0, 31'h0063_FFFF, 17'd65536);
		send_fiber(2'd0, MODE_SHRINK, 32'h0, 32'h0, 31'h0002_0000, 17'd0);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			load_config(phase == 0 ? 1 : phase == 1 ? 2 : 3 + phase);
			allow_gaps = (phase < 5);
			for (int n = 0; n < 250; n++)
				send_fiber($urandom, $urandom, pick_force(), pick_force(), pick_length(),
					pick_fraction());
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fegr_pkg.sv
rtl/core/fegr_cfg.sv
rtl/core/fegr_end_rate.sv
rtl/core/fegr_div.sv
rtl/core/fiber_end_growth_rate_core.sv
test/tb_fiber_end_growth_rate_core.sv
